// ----- rtl/core/sfr_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the signal frame receiver.
package sfr_pkg;

  localparam logic [7:0]  ESC_BYTE    = 8'h5c;
  localparam logic [7:0]  FLAG_BYTE   = 8'h7e;
  localparam logic [7:0]  ESC_ALT     = 8'h7d;
  localparam logic [15:0] MIN_FRAME   = 16'd17;
  localparam logic [15:0] CRC_POLY    = 16'h1005;
  localparam logic [15:0] CRC_INIT    = 16'h0000;
  localparam logic [15:0] LEN_OVERHEAD = 16'd4;
  localparam int          HDR_BYTES   = 13;
  localparam int          TAIL_BYTES  = 3;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_ENABLE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_CHECK_ENABLE = 1'd1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_SHORT = 2'd1,
    STATUS_LEN_ERR   = 2'd2,
    STATUS_CRC_ERR   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] length_field;
    logic [15:0] proto_version;
    logic [7:0]  center_id;
    logic [31:0] controller_id;
    logic [7:0]  crossing_id;
    logic [7:0]  seq_number;
    logic [7:0]  frame_type;
    logic [7:0]  item_count;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
  } result_t;

  typedef struct packed {
    logic [15:0]                     index;
    logic [15:0]                     crc;
    logic [TAIL_BYTES-1:0][7:0]      tail;
    logic [HDR_BYTES-1:0][7:0]       header;
  } plain_t;

  // MSB-first CRC-16 update by one byte
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/sfr_in_reg.sv -----
// Input word register of the signal frame receiver.
module sfr_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfr_pkg::in_word_t in_word,
  input  logic              take,
  output logic              word_valid,
  output sfr_pkg::in_word_t word
);
  import sfr_pkg::*;

  // free when empty or when the held word moves on this cycle
  assign in_ready = !word_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_word;
    end
  end

endmodule

// ----- rtl/core/sfr_core.sv -----
// Unstuffing, header capture, CRC and status evaluation for one byte per cycle whenever advance is high.
module sfr_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic                                cfg_data,
  input  logic                                advance,
  input  sfr_pkg::in_word_t                   word,
  output logic                                result_load,
  output sfr_pkg::result_t                    result
);
  import sfr_pkg::*;

  logic        escape_enable;
  logic        crc_check_enable;
  logic [15:0] raw_count;
  logic [15:0] raw_count_next;
  logic [15:0] raw_len;
  logic [15:0] raw_len_next;
  logic        escape_pending;
  logic        escape_pending_next;
  plain_t      plain;
  plain_t      plain_mid;
  plain_t      plain_next;
  logic        is_class;
  logic        dropped;
  logic        push_esc;
  logic [15:0] received;

  function automatic plain_t push_plain(plain_t s, logic [7:0] b);
    plain_t r;
    r = s;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (s.index == 16'(i + 1)) begin
        r.header[i] = b;
      end
    end
    if (s.index >= 16'd4) begin
      r.crc = crc_byte(s.crc, s.tail[0]);
    end
    r.tail[0] = s.tail[1];
    r.tail[1] = s.tail[2];
    r.tail[2] = b;
    if (s.index != 16'hffff) begin
      r.index = s.index + 16'd1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable    <= 1'b1;
      crc_check_enable <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ESCAPE_ENABLE:    escape_enable    <= cfg_data;
        CFG_CRC_CHECK_ENABLE: crc_check_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    raw_count_next = (raw_count != 16'hffff) ? raw_count + 16'd1 : raw_count;
    raw_len_next   = raw_len;
    if (raw_count == 16'd1) begin
      raw_len_next[15:8] = word.rx_byte;
    end else if (raw_count == 16'd2) begin
      raw_len_next[7:0] = word.rx_byte;
    end

    is_class = (word.rx_byte == FLAG_BYTE) || (word.rx_byte == ESC_ALT)
            || (word.rx_byte == ESC_BYTE);
    dropped  = escape_pending && escape_enable && is_class;
    push_esc = escape_pending && !dropped;
    escape_pending_next = !dropped && escape_enable && (word.rx_byte == ESC_BYTE)
                       && (raw_count != 16'd0) && !word.frame_end;

    plain_mid  = push_esc ? push_plain(plain, ESC_BYTE) : plain;
    plain_next = escape_pending_next ? plain_mid : push_plain(plain_mid, word.rx_byte);
  end

  always_comb begin
    received = {plain_next.tail[0], plain_next.tail[1]};
    if (raw_count_next < MIN_FRAME) begin
      result.status = STATUS_TOO_SHORT;
    end else if (raw_len_next != raw_count_next - LEN_OVERHEAD) begin
      result.status = STATUS_LEN_ERR;
    end else if (crc_check_enable && (plain_next.crc != received)) begin
      result.status = STATUS_CRC_ERR;
    end else begin
      result.status = STATUS_OK;
    end
    result.length_field  = {plain_next.header[0], plain_next.header[1]};
    result.proto_version = {plain_next.header[2], plain_next.header[3]};
    result.center_id     = plain_next.header[4];
    result.controller_id = {plain_next.header[5], plain_next.header[6],
                            plain_next.header[7], plain_next.header[8]};
    result.crossing_id   = plain_next.header[9];
    result.seq_number    = plain_next.header[10];
    result.frame_type    = plain_next.header[11];
    result.item_count    = plain_next.header[12];
    result.received_crc  = received;
    result.computed_crc  = plain_next.crc;
  end

  assign result_load = advance && word.frame_end;

  // frame state: clear at reset and after the last byte of a frame
  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      raw_count      <= '0;
      raw_len        <= '0;
      escape_pending <= 1'b0;
      plain          <= '{index: '0, crc: CRC_INIT, tail: '0, header: '0};
    end else if (advance) begin
      raw_count      <= raw_count_next;
      raw_len        <= raw_len_next;
      escape_pending <= escape_pending_next;
      plain          <= plain_next;
    end
  end

endmodule

// ----- rtl/core/sfr_out_reg.sv -----
// Result register of the signal frame receiver.
module sfr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfr_pkg::result_t result_in,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output sfr_pkg::result_t result_out
);
  import sfr_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      result_out <= result_in;
    end
  end

endmodule

// ----- rtl/core/signal_frame_receiver.sv -----
// Top level of the signal frame receiver: byte-stuffed frame deframer with CRC-16 check.
//
// Usage:
//   Input channel (in_valid/in_ready): one raw frame byte per word on rx_byte,
//   frame_end high on the last byte of a frame. Every byte is taken; only the
//   last byte of a frame produces an output word.
//   Output channel (out_valid/out_ready): one word per frame carrying status
//   (ok, too short, length mismatch, crc mismatch) and the captured header,
//   received CRC and computed CRC.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
//   escape_enable, index 1 is crc_check_enable; always ready, write only
//   while no frame is in progress.
// Timing: one byte per cycle sustained while no last byte waits for room in the
//   result register. A frame's last byte is loaded into the input register
//   when accepted and then, through the unstuff/CRC logic, into the result
//   register that drives the output. The rate is set by the byte-wide CRC
//   update feeding the frame state registers.
// Reset: both config bits go to 1, frame state clears, both channels empty.
// Stall: while a result waits on out_ready, ordinary bytes keep flowing; a
//   next last byte holds in the input register until the result is taken.
module signal_frame_receiver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  input  logic                            frame_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [15:0]                     length_field,
  output logic [15:0]                     proto_version,
  output logic [7:0]                      center_id,
  output logic [31:0]                     controller_id,
  output logic [7:0]                      crossing_id,
  output logic [7:0]                      seq_number,
  output logic [7:0]                      frame_type,
  output logic [7:0]                      item_count,
  output logic [15:0]                     received_crc,
  output logic [15:0]                     computed_crc,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                            cfg_data
);
  import sfr_pkg::*;

  in_word_t in_word;
  in_word_t word;
  logic     word_valid;
  logic     advance;
  logic     out_free;
  logic     result_load;
  result_t  result;
  result_t  result_q;

  assign in_word.rx_byte   = rx_byte;
  assign in_word.frame_end = frame_end;

  // config writes are always accepted and registered in the core
  assign cfg_ready = 1'b1;

  // advance a held word; a last byte waits for room in the result register
  assign advance = word_valid && (!word.frame_end || out_free);

  sfr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .take       (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  sfr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .advance     (advance),
    .word        (word),
    .result_load (result_load),
    .result      (result)
  );

  sfr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (result_load),
    .result_in  (result),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_q)
  );

  assign status        = result_q.status;
  assign length_field  = result_q.length_field;
  assign proto_version = result_q.proto_version;
  assign center_id     = result_q.center_id;
  assign controller_id = result_q.controller_id;
  assign crossing_id   = result_q.crossing_id;
  assign seq_number    = result_q.seq_number;
  assign frame_type    = result_q.frame_type;
  assign item_count    = result_q.item_count;
  assign received_crc  = result_q.received_crc;
  assign computed_crc  = result_q.computed_crc;

endmodule
